// File: rtl/core/bgps_pkg.sv
// Package for the battery gauge: payload structs, queue entry, configuration set,
// register map, reset values and the voltage breakpoint table.
// Used by every module in rtl/core; depends on nothing.
package bgps_pkg;

  typedef struct packed {
    logic [12:0] battery_mv;
    logic        is_charging;
  } in_item_t;

  typedef struct packed {
    logic [6:0] shown_percent;
    logic       battery_low;
  } out_item_t;

  typedef struct packed {
    logic [12:0] low_threshold_mv;
    logic [9:0]  low_hysteresis_mv;
    logic [7:0]  low_count_limit;
    logic [9:0]  rise_period_ticks;
    logic [9:0]  fall_period_ticks;
  } cfg_t;

  // One classified tick travelling from front to back
  typedef struct packed {
    logic [12:0] diff;    // voltage above the segment's lower breakpoint
    logic [12:0] den;     // segment width in mV
    logic [4:0]  span;    // percent covered by the segment
    logic [6:0]  base;    // percent at the segment's lower breakpoint
    logic        direct;  // target is base alone, no interpolation
    logic        chg;
    logic        low;     // low latch after this tick's update
  } job_t;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  localparam logic [2:0] REG_LOW_THRESHOLD  = 3'd0;
  localparam logic [2:0] REG_LOW_HYSTERESIS = 3'd1;
  localparam logic [2:0] REG_LOW_COUNT      = 3'd2;
  localparam logic [2:0] REG_RISE_PERIOD    = 3'd3;
  localparam logic [2:0] REG_FALL_PERIOD    = 3'd4;

  localparam logic [12:0] RST_LOW_THRESHOLD  = 13'd3300;
  localparam logic [9:0]  RST_LOW_HYSTERESIS = 10'd100;
  localparam logic [7:0]  RST_LOW_COUNT      = 8'd10;
  localparam logic [9:0]  RST_RISE_PERIOD    = 10'd500;
  localparam logic [9:0]  RST_FALL_PERIOD    = 10'd200;

  // Fixed breakpoints above the programmable threshold
  localparam logic [12:0] BP_A = 13'd3350;
  localparam logic [12:0] BP_B = 13'd3750;
  localparam logic [12:0] BP_C = 13'd3850;
  localparam logic [12:0] BP_D = 13'd4000;
  localparam logic [12:0] BP_E = 13'd4200;

  localparam logic [6:0] PCT_FULL  = 7'd100;
  localparam logic [7:0] LOW_SAT   = 8'd255;
  localparam logic [9:0] SLEW_MAX  = 10'd1023;

  // Quotient bits of the interpolation: every span is below 32
  localparam int unsigned QUOT_W = 5;

endpackage

// File: rtl/core/battery_gauge_percent_slew.sv
// Top level of the battery gauge: configuration registers on an APB-style port,
// front end, tick queue and back end. Depends on bgps_pkg, bgps_front,
// bgps_queue and bgps_back.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+--------------------------
//   in       | input     | in_valid_i / in_ready_o  | in_data_i  (in_item_t)
//   out      | output    | out_valid_o / out_ready_i| out_data_o (out_item_t)
//   config   | input     | psel/penable/pwrite      | paddr, pwdata, prdata
//
// An interpolated tick passes through the back end as one load, five divider
// steps of the five-bit restoring divider and one finish. A tick below the
// threshold or at full charge skips the divider and goes from load to finish.
// The front end takes a tick per cycle while the queue has room, so up to
// QueueDepth ticks wait. The result register lets the back end load the next
// tick while a result waits; the next finish waits until it is taken.
// Reset clears the low latch, the shown level, the slew count and the queue.
module battery_gauge_percent_slew #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bgps_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bgps_pkg::out_item_t           out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bgps_pkg::PADDR_W-1:0]  paddr,
  input  logic [bgps_pkg::PDATA_W-1:0]  pwdata,
  output logic [bgps_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  bgps_pkg::cfg_t cfg_q;
  logic [2:0]     reg_idx;
  logic           reg_wr;

  logic           push, push_ready, pop, pop_valid;
  bgps_pkg::job_t push_job, pop_job;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_threshold_mv  <= bgps_pkg::RST_LOW_THRESHOLD;
      cfg_q.low_hysteresis_mv <= bgps_pkg::RST_LOW_HYSTERESIS;
      cfg_q.low_count_limit   <= bgps_pkg::RST_LOW_COUNT;
      cfg_q.rise_period_ticks <= bgps_pkg::RST_RISE_PERIOD;
      cfg_q.fall_period_ticks <= bgps_pkg::RST_FALL_PERIOD;
    end else if (reg_wr) begin
      unique case (reg_idx)
        bgps_pkg::REG_LOW_THRESHOLD:  cfg_q.low_threshold_mv  <= pwdata[12:0];
        bgps_pkg::REG_LOW_HYSTERESIS: cfg_q.low_hysteresis_mv <= pwdata[9:0];
        bgps_pkg::REG_LOW_COUNT:      cfg_q.low_count_limit   <= pwdata[7:0];
        bgps_pkg::REG_RISE_PERIOD:    cfg_q.rise_period_ticks <= pwdata[9:0];
        bgps_pkg::REG_FALL_PERIOD:    cfg_q.fall_period_ticks <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bgps_pkg::REG_LOW_THRESHOLD:  prdata = 32'(cfg_q.low_threshold_mv);
      bgps_pkg::REG_LOW_HYSTERESIS: prdata = 32'(cfg_q.low_hysteresis_mv);
      bgps_pkg::REG_LOW_COUNT:      prdata = 32'(cfg_q.low_count_limit);
      bgps_pkg::REG_RISE_PERIOD:    prdata = 32'(cfg_q.rise_period_ticks);
      bgps_pkg::REG_FALL_PERIOD:    prdata = 32'(cfg_q.fall_period_ticks);
      default:                      prdata = '0;
    endcase
  end

  bgps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_ready_o   (in_ready_o),
    .push_ready_i (push_ready),
    .push_o       (push),
    .job_o        (push_job)
  );

  bgps_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_job),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_job)
  );

  bgps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/core/bgps_front.sv
// Front end of the battery gauge: accepts ticks, runs the low-battery latch and
// picks the voltage segment for interpolation.
// Depends on bgps_pkg.
module bgps_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bgps_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  input  bgps_pkg::in_item_t in_data_i,
  output logic              in_ready_o,
  input  logic              push_ready_i,
  output logic              push_o,
  output bgps_pkg::job_t    job_o
);

  logic [7:0]  low_cnt_q, low_cnt_d;
  logic        low_q, low_d;
  logic [7:0]  cnt_inc, cnt_mid;
  logic [13:0] clear_level;
  logic        clear_cnt;
  logic [12:0] mv;
  logic [5:0]  ge;
  logic [2:0]  seg;
  logic [12:0] lo, hi;

  assign mv         = in_data_i.battery_mv;
  assign in_ready_o = push_ready_i;
  assign push_o     = in_valid_i & push_ready_i;

  // Low-battery latch
  always_comb begin
    cnt_inc     = (low_cnt_q != bgps_pkg::LOW_SAT) ? low_cnt_q + 8'd1 : low_cnt_q;
    clear_level = {1'b0, cfg_i.low_threshold_mv} + {4'd0, cfg_i.low_hysteresis_mv};
    if (low_q) begin
      clear_cnt = in_data_i.is_charging && ({1'b0, mv} >= clear_level);
    end else begin
      clear_cnt = (mv >= cfg_i.low_threshold_mv);
    end
    cnt_mid = clear_cnt ? 8'd0 : cnt_inc;
    if (cnt_mid >= cfg_i.low_count_limit) begin
      low_d     = 1'b1;
      low_cnt_d = cfg_i.low_count_limit;
    end else begin
      low_d     = 1'b0;
      low_cnt_d = cnt_mid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_cnt_q <= 8'd0;
      low_q     <= 1'b0;
    end else if (push_o) begin
      low_cnt_q <= low_cnt_d;
      low_q     <= low_d;
    end
  end

  // Segment search: stop at the first breakpoint above the voltage
  always_comb begin
    ge[0] = (mv >= cfg_i.low_threshold_mv);
    ge[1] = (mv >= bgps_pkg::BP_A);
    ge[2] = (mv >= bgps_pkg::BP_B);
    ge[3] = (mv >= bgps_pkg::BP_C);
    ge[4] = (mv >= bgps_pkg::BP_D);
    ge[5] = (mv >= bgps_pkg::BP_E);
    seg = 3'd6;
    for (int k = 5; k >= 0; k--) begin
      if (!ge[k]) begin
        seg = 3'(k);
      end
    end
  end

  always_comb begin
    lo           = 13'd0;
    hi           = 13'd0;
    job_o.span   = 5'd0;
    job_o.base   = 7'd0;
    job_o.direct = 1'b0;
    unique case (seg)
      3'd1: begin
        lo = cfg_i.low_threshold_mv; hi = bgps_pkg::BP_A;
        job_o.span = 5'd1;  job_o.base = 7'd1;
      end
      3'd2: begin
        lo = bgps_pkg::BP_A; hi = bgps_pkg::BP_B;
        job_o.span = 5'd23; job_o.base = 7'd2;
      end
      3'd3: begin
        lo = bgps_pkg::BP_B; hi = bgps_pkg::BP_C;
        job_o.span = 5'd25; job_o.base = 7'd25;
      end
      3'd4: begin
        lo = bgps_pkg::BP_C; hi = bgps_pkg::BP_D;
        job_o.span = 5'd25; job_o.base = 7'd50;
      end
      3'd5: begin
        lo = bgps_pkg::BP_D; hi = bgps_pkg::BP_E;
        job_o.span = 5'd25; job_o.base = 7'd75;
      end
      3'd6: begin
        job_o.direct = 1'b1;
        job_o.base   = bgps_pkg::PCT_FULL;
      end
      default: begin
        job_o.direct = 1'b1;
      end
    endcase
    job_o.diff = mv - lo;
    job_o.den  = hi - lo;
    job_o.chg  = in_data_i.is_charging;
    job_o.low  = low_d;
  end

endmodule

// File: rtl/core/bgps_queue.sv
// Short FIFO of classified ticks between front and back of the battery gauge.
// Depends on bgps_pkg.
module bgps_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bgps_pkg::job_t push_data_i,
  output logic           push_ready_o,
  input  logic           pop_i,
  output logic           pop_valid_o,
  output bgps_pkg::job_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  bgps_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// File: rtl/core/bgps_back.sv
// Back end of the battery gauge: interpolates the target percent with a
// restoring divider, slews the shown level and holds the result register.
// Depends on bgps_pkg.
module bgps_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bgps_pkg::cfg_t      cfg_i,
  input  logic                pop_valid_i,
  input  bgps_pkg::job_t      pop_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bgps_pkg::out_item_t out_data_o
);

  localparam logic [1:0] BS_IDLE = 2'd0;
  localparam logic [1:0] BS_DIV  = 2'd1;
  localparam logic [1:0] BS_DONE = 2'd2;

  localparam int unsigned RemW = 18;

  logic [1:0]  state_q, state_d;
  logic [RemW-1:0] rem_q, rem_d, trial;
  logic [12:0] den_q, den_d;
  logic [bgps_pkg::QUOT_W-1:0] quot_q, quot_d;
  logic [2:0]  step_q, step_d;
  bgps_pkg::job_t job_q, job_d;

  logic [6:0]  level_q, level_d;
  logic [9:0]  slew_q, slew_d, slew_inc;
  logic        started_q, started_d;
  logic [6:0]  target;
  logic        finish;

  logic                out_valid_q, out_valid_d;
  bgps_pkg::out_item_t out_q, out_d;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pop_o       = (state_q == BS_IDLE) && pop_valid_i;
  assign finish      = (state_q == BS_DONE) && (!out_valid_q || out_ready_i);
  assign trial       = RemW'(den_q) << step_q;
  assign target      = job_q.base + 7'(quot_q);

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quot_d  = quot_q;
    step_d  = step_q;
    job_d   = job_q;
    unique case (state_q)
      BS_IDLE: begin
        if (pop_valid_i) begin
          job_d   = pop_data_i;
          rem_d   = RemW'(pop_data_i.diff) * RemW'(pop_data_i.span);
          den_d   = pop_data_i.den;
          quot_d  = '0;
          step_d  = 3'(bgps_pkg::QUOT_W - 1);
          state_d = pop_data_i.direct ? BS_DONE : BS_DIV;
        end
      end
      BS_DIV: begin
        // one quotient bit per cycle, most significant first
        if (rem_q >= trial) begin
          rem_d  = rem_q - trial;
          quot_d = {quot_q[bgps_pkg::QUOT_W-2:0], 1'b1};
        end else begin
          quot_d = {quot_q[bgps_pkg::QUOT_W-2:0], 1'b0};
        end
        if (step_q == 3'd0) begin
          state_d = BS_DONE;
        end else begin
          step_d = step_q - 3'd1;
        end
      end
      BS_DONE: begin
        if (finish) begin
          state_d = BS_IDLE;
        end
      end
      default: begin
        state_d = BS_IDLE;
      end
    endcase
  end

  // Slew of the shown level
  always_comb begin
    level_d   = level_q;
    slew_d    = slew_q;
    started_d = 1'b1;
    slew_inc  = (slew_q != bgps_pkg::SLEW_MAX) ? slew_q + 10'd1 : slew_q;
    if (!started_q) begin
      level_d = target;
    end else if (job_q.chg) begin
      if (target <= level_q) begin
        slew_d = 10'd0;
      end else if (slew_inc >= cfg_i.rise_period_ticks) begin
        slew_d  = 10'd0;
        level_d = level_q + 7'd1;
      end else begin
        slew_d = slew_inc;
      end
    end else begin
      if (target >= level_q) begin
        slew_d = 10'd0;
      end else if (slew_inc >= cfg_i.fall_period_ticks) begin
        slew_d  = 10'd0;
        level_d = level_q - 7'd1;
      end else begin
        slew_d = slew_inc;
      end
    end
    if (job_q.low) begin
      level_d = 7'd0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (finish) begin
      out_valid_d         = 1'b1;
      out_d.shown_percent = level_d;
      out_d.battery_low   = job_q.low;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
    step_q <= step_d;
    job_q  <= job_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      out_valid_q <= 1'b0;
      level_q     <= 7'd0;
      slew_q      <= 10'd0;
      started_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (finish) begin
        level_q   <= level_d;
        slew_q    <= slew_d;
        started_q <= started_d;
      end
    end
  end

endmodule

// File: bench/battery_gauge_percent_slew_tb.sv
// Self-checking bench for battery_gauge_percent_slew: random voltage ticks, APB register
// settings and handshake stalls, with every reading checked against an in-bench predictor.
// Depends on bgps_pkg and the battery_gauge_percent_slew RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REG_COUNT = 5;
  localparam int REG_SLOTS = 8;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  bgps_pkg::in_item_t            in_data_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  bgps_pkg::out_item_t           out_data_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [bgps_pkg::PADDR_W-1:0]  paddr;
  logic [bgps_pkg::PDATA_W-1:0]  pwdata;
  logic [bgps_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  // Predictor state and register copy
  bgps_pkg::cfg_t gauge_cfg;
  logic [6:0]     gauge_level;
  logic [9:0]     step_count;
  logic           gauge_started;
  logic           low_flag;
  logic [7:0]     under_count;

  bgps_pkg::out_item_t expected_readings[$];
  int          mismatches = 0;
  int          ticks_sent = 0;
  int          readings_seen = 0;
  int          settings_used = 0;
  int          low_readings = 0;
  int          slew_steps = 0;
  bit          idling_on;
  int          hold_off_cycles;

  battery_gauge_percent_slew dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic flag_error(input string what, input int got, input int want);
    $display("ERROR at %0t ns: %s got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic int knee_mv(input int idx);
    case (idx)
      0: return gauge_cfg.low_threshold_mv;
      1: return bgps_pkg::BP_A;
      2: return bgps_pkg::BP_B;
      3: return bgps_pkg::BP_C;
      4: return bgps_pkg::BP_D;
      default: return bgps_pkg::BP_E;
    endcase
  endfunction

  // Piecewise-linear voltage to percent; first knee above the voltage picks the segment
  function automatic int target_pct(input int mv);
    int seg, lo, hi, base, span;
    seg = 0;
    while (seg < 6 && mv >= knee_mv(seg)) seg++;
    if (seg == 0) return 0;
    if (seg == 6) return bgps_pkg::PCT_FULL;
    lo = knee_mv(seg - 1);
    hi = knee_mv(seg);
    case (seg)
      1: begin base = 1;  span = 1;  end
      2: begin base = 2;  span = 23; end
      3: begin base = 25; span = 25; end
      4: begin base = 50; span = 25; end
      default: begin base = 75; span = 25; end
    endcase
    if (hi <= lo || mv < lo) return base;
    return (mv - lo) * span / (hi - lo) + base;
  endfunction

  function automatic bgps_pkg::out_item_t advance_gauge(input bgps_pkg::in_item_t tick);
    int mv, target;
    bgps_pkg::out_item_t reading;
    mv = tick.battery_mv;
    if (under_count != bgps_pkg::LOW_SAT) under_count++;
    if (low_flag) begin
      if (tick.is_charging &&
          mv >= int'(gauge_cfg.low_threshold_mv) + int'(gauge_cfg.low_hysteresis_mv))
        under_count = '0;
    end else if (mv >= int'(gauge_cfg.low_threshold_mv)) begin
      under_count = '0;
    end
    if (under_count >= gauge_cfg.low_count_limit) begin
      low_flag = 1'b1;
      under_count = gauge_cfg.low_count_limit;
    end else begin
      low_flag = 1'b0;
    end

    target = target_pct(mv);
    if (gauge_started) begin
      if (step_count != bgps_pkg::SLEW_MAX) step_count++;
      if (tick.is_charging) begin
        if (target <= int'(gauge_level)) begin
          step_count = '0;
        end else if (step_count >= gauge_cfg.rise_period_ticks) begin
          step_count = '0;
          gauge_level++;
          slew_steps++;
        end
      end else begin
        if (target >= int'(gauge_level)) begin
          step_count = '0;
        end else if (step_count >= gauge_cfg.fall_period_ticks) begin
          step_count = '0;
          gauge_level--;
          slew_steps++;
        end
      end
    end else begin
      gauge_level = 7'(target);
      gauge_started = 1'b1;
    end
    if (low_flag) gauge_level = '0;

    reading.shown_percent = gauge_level;
    reading.battery_low = low_flag;
    return reading;
  endfunction

  // Receiver: random ready bursts, or one long counted hold-off on request
  always begin : receiver
    int burst;
    @(negedge clk_i);
    if (hold_off_cycles != 0) begin
      burst = hold_off_cycles;
      hold_off_cycles = 0;
      out_ready_i <= 1'b0;
    end else if (idling_on && $urandom_range(0, 3) == 0) begin
      burst = $urandom_range(1, 16);
      out_ready_i <= 1'b0;
    end else begin
      burst = $urandom_range(1, 16);
      out_ready_i <= 1'b1;
    end
    repeat (burst - 1) @(negedge clk_i);
  end

  always @(posedge clk_i) begin : reading_check
    bgps_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      readings_seen++;
      if (out_data_o.battery_low) low_readings++;
      if (expected_readings.size() == 0) begin
        flag_error("reading with no tick outstanding", out_data_o, 0);
      end else begin
        want = expected_readings.pop_front();
        if (out_data_o.shown_percent !== want.shown_percent)
          flag_error("shown_percent", out_data_o.shown_percent, want.shown_percent);
        if (out_data_o.battery_low !== want.battery_low)
          flag_error("battery_low", out_data_o.battery_low, want.battery_low);
      end
    end
  end

  task automatic send_tick(input int mv, input bit chg);
    bgps_pkg::in_item_t tick;
    tick.battery_mv = 13'(mv);
    tick.is_charging = chg;
    @(negedge clk_i);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= tick;
    do @(posedge clk_i); while (!in_ready_o);
    expected_readings.push_back(advance_gauge(tick));
    ticks_sent++;
  endtask

  // Drop valid and hold until every outstanding reading has been taken
  task automatic drain_readings();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      bgps_pkg::REG_LOW_THRESHOLD:  gauge_cfg.low_threshold_mv = value[12:0];
      bgps_pkg::REG_LOW_HYSTERESIS: gauge_cfg.low_hysteresis_mv = value[9:0];
      bgps_pkg::REG_LOW_COUNT:      gauge_cfg.low_count_limit = value[7:0];
      bgps_pkg::REG_RISE_PERIOD:    gauge_cfg.rise_period_ticks = value[9:0];
      bgps_pkg::REG_FALL_PERIOD:    gauge_cfg.fall_period_ticks = value[9:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_gauge(input int thr, input int hyst, input int limit,
                           input int rise, input int fall);
    drain_readings();
    write_reg(bgps_pkg::REG_LOW_THRESHOLD, thr);
    write_reg(bgps_pkg::REG_LOW_HYSTERESIS, hyst);
    write_reg(bgps_pkg::REG_LOW_COUNT, limit);
    write_reg(bgps_pkg::REG_RISE_PERIOD, rise);
    write_reg(bgps_pkg::REG_FALL_PERIOD, fall);
    settings_used++;
  endtask

  // Stretches of fixed charger state around a drifting voltage level
  task automatic drive_walk(input int count);
    int level, stretch;
    bit chg;
    while (count > 0) begin
      level = $urandom_range(3000, 4400);
      chg = $urandom_range(0, 1);
      stretch = $urandom_range(3, 10);
      while (stretch > 0 && count > 0) begin
        send_tick(level + $urandom_range(0, 60) - 30, chg);
        stretch--;
        count--;
      end
    end
  endtask

  task automatic test_table_and_edges();
    int probes [12];
    probes = '{3349, 3350, 3499, 3500, 3749, 3750, 3849, 3850, 3999, 4000, 4199, 4200};
    // first tick loads the shown level straight from the table
    send_tick(3800, 1'b0);
    send_tick(8191, 1'b1);
    send_tick(0, 1'b0);
    // threshold above the first fixed knee; zero periods step on every tick away from target
    set_gauge(3500, 1023, 20, 0, 0);
    write_reg(3'($urandom_range(REG_COUNT, REG_SLOTS - 1)), $urandom());
    for (int i = 0; i < 12; i++) send_tick(probes[i], i[0]);
    // zero count limit latches on every tick
    set_gauge(0, 0, 0, 1023, 1023);
    send_tick(0, 1'b1);
    send_tick(8191, 1'b1);
    set_gauge(8191, 1023, 255, 1, 1);
    send_tick(8190, 1'b0);
    send_tick(8191, 1'b1);
  endtask

  task automatic test_low_latch();
    int limit, thr, hyst;
    // saturate the under-voltage count at its ceiling, then clear it by charging
    set_gauge(bgps_pkg::RST_LOW_THRESHOLD, bgps_pkg::RST_LOW_HYSTERESIS,
              bgps_pkg::LOW_SAT, 2, 2);
    repeat (260)
      send_tick($urandom_range(0, bgps_pkg::RST_LOW_THRESHOLD - 1), $urandom_range(0, 1));
    send_tick($urandom_range(3300, 3399), 1'b1);
    send_tick($urandom_range(3400, 8191), 1'b0);
    send_tick($urandom_range(3400, 8191), 1'b1);
    repeat (3) begin
      limit = $urandom_range(1, 8);
      thr = $urandom_range(3100, 3500);
      hyst = $urandom_range(0, 300);
      set_gauge(thr, hyst, limit, $urandom_range(1, 4), $urandom_range(1, 4));
      repeat (5) begin
        repeat ($urandom_range(0, limit + 3))
          send_tick($urandom_range(0, thr - 1), $urandom_range(0, 1));
        repeat (4) begin
          case ($urandom_range(0, 3))
            0: send_tick($urandom_range(0, thr - 1), 1'b1);
            1: send_tick(thr + $urandom_range(0, hyst), 1'b1);
            2: send_tick($urandom_range(thr, 8191), 1'b0);
            default: send_tick($urandom_range(thr + hyst, 4300), 1'b1);
          endcase
        end
      end
    end
  endtask

  task automatic test_slew_walks();
    repeat (5) begin
      set_gauge($urandom_range(3000, 3400), $urandom_range(0, 200), $urandom_range(20, 255),
                $urandom_range(1, 6), $urandom_range(1, 6));
      drive_walk(40);
    end
    set_gauge(3300, 100, 255, 1023, 1);
    drive_walk(20);
  endtask

  task automatic test_full_range_noise();
    repeat (2) begin
      set_gauge($urandom_range(0, 8191), $urandom_range(0, 1023), $urandom_range(0, 255),
                $urandom_range(0, 1023), $urandom_range(0, 1023));
      repeat (20) send_tick($urandom_range(0, 8191), $urandom_range(0, 1));
    end
  endtask

  task automatic test_backpressure();
    set_gauge(3200, 50, 30, 2, 3);
    // hold the output long enough for the queue to fill and stall the input
    hold_off_cycles = 80;
    drive_walk(24);
    drain_readings();
    drive_walk(16);
  endtask

  task automatic test_steady_stream();
    idling_on = 1'b0;
    set_gauge($urandom_range(3100, 3400), $urandom_range(0, 150), $urandom_range(5, 40),
              $urandom_range(1, 5), $urandom_range(1, 5));
    drive_walk(60);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idling_on = 1'b1;
    hold_off_cycles = 0;
    gauge_cfg.low_threshold_mv = bgps_pkg::RST_LOW_THRESHOLD;
    gauge_cfg.low_hysteresis_mv = bgps_pkg::RST_LOW_HYSTERESIS;
    gauge_cfg.low_count_limit = bgps_pkg::RST_LOW_COUNT;
    gauge_cfg.rise_period_ticks = bgps_pkg::RST_RISE_PERIOD;
    gauge_cfg.fall_period_ticks = bgps_pkg::RST_FALL_PERIOD;
    gauge_level = '0;
    step_count = '0;
    gauge_started = 1'b0;
    low_flag = 1'b0;
    under_count = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_table_and_edges();
    test_low_latch();
    test_slew_walks();
    test_full_range_noise();
    test_backpressure();
    test_steady_stream();

    drain_readings();
    repeat (16) @(posedge clk_i);
    $display("Sent %0d ticks under %0d register settings, checked %0d readings.",
             ticks_sent, settings_used, readings_seen);
    $display("Low flag held on %0d readings; shown level slewed %0d times.",
             low_readings, slew_steps);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
